// ===== rtl/rvr_pkg.sv =====
`timescale 1ns / 1ps
package rvr_pkg;

  // Datapath widths. CORDIC x and y are Q30 and stay near unit magnitude.
  localparam int unsigned CxW   = 34;
  localparam int unsigned CzW   = 35;
  // Multiplier operands and products, wide enough for every term of the formula.
  localparam int unsigned MulW  = 41;
  localparam int unsigned ProdW = 48;
  localparam int unsigned MagW  = MulW - 1;
  localparam int unsigned HalfW = MagW / 2;
  localparam int unsigned QShift = 30;

  localparam logic signed [CzW-1:0] Q30Pi     = 35'sd3373259426;
  localparam logic signed [CzW-1:0] Q30HalfPi = 35'sd1686629713;
  localparam logic signed [CxW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [35:0]    Q30One    = 36'sd1073741824;

  // Arctangent of 2^-i in Q30, rounded to nearest.
  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0:  r = 30'd843314857;
      1:  r = 30'd497837829;
      2:  r = 30'd263043837;
      3:  r = 30'd133525159;
      4:  r = 30'd67021687;
      5:  r = 30'd33543516;
      6:  r = 30'd16775851;
      7:  r = 30'd8388437;
      8:  r = 30'd4194283;
      9:  r = 30'd2097149;
      10: r = 30'd1048576;
      11: r = 30'd524288;
      12: r = 30'd262144;
      13: r = 30'd131072;
      14: r = 30'd65536;
      15: r = 30'd32768;
      16: r = 30'd16384;
      17: r = 30'd8192;
      18: r = 30'd4096;
      19: r = 30'd2048;
      20: r = 30'd1024;
      21: r = 30'd512;
      22: r = 30'd256;
      23: r = 30'd128;
      24: r = 30'd64;
      25: r = 30'd32;
      26: r = 30'd16;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rodrigues_vector_rotation.sv =====
`timescale 1ns / 1ps
// Rotates a 3D vector about a unit axis by Rodrigues' formula.
// The slave channel takes one request per cycle while the output buffer
// has room: tdata carries the vector (Q15.16), the axis (Q1.30) and the
// angle (Q2.28 radians). The master channel returns the rotated vector,
// each component saturated to 32 bits. Throughput is one request per
// cycle while the buffer has room. The pipeline is the input stage, the
// chain of CORDIC cells, one per iteration, three levels of pipelined
// multipliers, a summing stage and the output buffer.
// A two-entry output buffer holds finished results; the whole pipeline
// advances while the buffer has room, so requests keep flowing while one
// result waits. When the receiver stalls long enough to fill the buffer,
// s_axis_tready_o drops and every stage holds.
// Reset empties the pipeline and the buffer; no result is pending after it.
module rodrigues_vector_rotation #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle, one zero pad bit
  input  logic [223:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rot_x, rot_y, rot_z
  output logic [95:0]  m_axis_tdata_o
);
  import rvr_pkg::*;

  localparam int unsigned N = CORDIC_ITERATIONS;
  localparam int unsigned MulLat = 3;

  logic adv;

  // ---------------- input stage: fold the angle ----------------
  logic                  vld0_q, flip0_q;
  logic signed [CzW-1:0] z0_q, a4;
  logic [191:0]          vk0_q;

  assign a4 = CzW'($signed({s_axis_tdata_i[222:192], 2'b00}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (adv) begin
      vld0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vk0_q <= s_axis_tdata_i[191:0];
      if (a4 > Q30HalfPi) begin
        z0_q    <= a4 - Q30Pi;
        flip0_q <= 1'b1;
      end else if (a4 < -Q30HalfPi) begin
        z0_q    <= a4 + Q30Pi;
        flip0_q <= 1'b1;
      end else begin
        z0_q    <= a4;
        flip0_q <= 1'b0;
      end
    end
  end

  // ---------------- CORDIC cell chain ----------------
  logic signed [CxW-1:0] xs [N+1];
  logic signed [CxW-1:0] ys [N+1];
  logic signed [CzW-1:0] zs [N+1];

  assign xs[0] = CordicGain;
  assign ys[0] = '0;
  assign zs[0] = z0_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rvr_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .z_i   (zs[i]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .z_o   (zs[i+1])
    );
  end

  logic [193:0] c1_in, c1_out;
  assign c1_in = {vld0_q, flip0_q, vk0_q};

  rvr_delay #(.W(194), .D(N)) u_dly_cordic (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .d_i (c1_in), .d_o (c1_out)
  );

  logic                  vld1, flip1;
  logic signed [CxW-1:0] cosv, sinv;
  logic signed [35:0]    omc1;
  logic signed [MulW-1:0] v1 [3];
  logic signed [MulW-1:0] k1 [3];

  assign vld1  = c1_out[193];
  assign flip1 = c1_out[192];
  assign cosv  = flip1 ? -xs[N] : xs[N];
  assign sinv  = flip1 ? -ys[N] : ys[N];
  assign omc1  = Q30One - 36'(cosv);

  for (genvar j = 0; j < 3; j++) begin : g_unpack
    assign v1[j] = MulW'($signed(c1_out[32*j +: 32]));
    assign k1[j] = MulW'($signed(c1_out[96 + 32*j +: 32]));
  end

  // ---------------- first products: k.v terms and v*cos ----------------
  logic signed [ProdW-1:0] kv [3][3];
  logic signed [ProdW-1:0] vc [3];

  for (genvar a = 0; a < 3; a++) begin : g_kv_a
    for (genvar b = 0; b < 3; b++) begin : g_kv_b
      rvr_mul u_mul (
        .clk_i (clk_i), .en_i (adv), .a_i (k1[a]), .b_i (v1[b]), .p_o (kv[a][b])
      );
    end
    rvr_mul u_mul_c (
      .clk_i (clk_i), .en_i (adv), .a_i (v1[a]), .b_i (MulW'(cosv)), .p_o (vc[a])
    );
  end

  logic [166:0] c2_in, c2_out;
  assign c2_in = {vld1, CxW'(sinv), omc1, c1_out[191:96]};

  rvr_delay #(.W(167), .D(MulLat)) u_dly_p1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .d_i (c2_in), .d_o (c2_out)
  );

  // ---------------- dot and cross sums ----------------
  logic                    vld2_q;
  logic signed [CxW-1:0]   sin2_q;
  logic signed [35:0]      omc2_q;
  logic [95:0]             k2_q;
  logic signed [ProdW-1:0] dot_q;
  logic signed [ProdW-1:0] cr_q [3];
  logic signed [ProdW-1:0] vc2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (adv) begin
      vld2_q <= c2_out[166];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sin2_q   <= $signed(c2_out[165:132]);
      omc2_q   <= $signed(c2_out[131:96]);
      k2_q     <= c2_out[95:0];
      dot_q    <= kv[0][0] + kv[1][1] + kv[2][2];
      cr_q[0]  <= kv[1][2] - kv[2][1];
      cr_q[1]  <= kv[2][0] - kv[0][2];
      cr_q[2]  <= kv[0][1] - kv[1][0];
      for (int j = 0; j < 3; j++) vc2_q[j] <= vc[j];
    end
  end

  // ---------------- second products: k*dot and cross*sin ----------------
  logic signed [ProdW-1:0] kd [3];
  logic signed [ProdW-1:0] crs [3];

  for (genvar j = 0; j < 3; j++) begin : g_p2
    rvr_mul u_mul_kd (
      .clk_i (clk_i), .en_i (adv),
      .a_i (MulW'($signed(k2_q[32*j +: 32]))), .b_i (MulW'(dot_q)), .p_o (kd[j])
    );
    rvr_mul u_mul_cs (
      .clk_i (clk_i), .en_i (adv),
      .a_i (MulW'(cr_q[j])), .b_i (MulW'(sin2_q)), .p_o (crs[j])
    );
  end

  logic [180:0] c3_in, c3_out;
  assign c3_in = {vld2_q, omc2_q, vc2_q[2], vc2_q[1], vc2_q[0]};

  rvr_delay #(.W(181), .D(MulLat)) u_dly_p2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .d_i (c3_in), .d_o (c3_out)
  );

  // ---------------- third products: k*dot*(1-cos) ----------------
  logic signed [ProdW-1:0] kdo [3];

  for (genvar j = 0; j < 3; j++) begin : g_p3
    rvr_mul u_mul_ko (
      .clk_i (clk_i), .en_i (adv),
      .a_i (MulW'(kd[j])), .b_i (MulW'($signed(c3_out[179:144]))), .p_o (kdo[j])
    );
  end

  logic [288:0] c4_in, c4_out;
  assign c4_in = {c3_out[180], crs[2], crs[1], crs[0], c3_out[143:0]};

  rvr_delay #(.W(289), .D(MulLat)) u_dly_p3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv), .d_i (c4_in), .d_o (c4_out)
  );

  // ---------------- final sum and saturation ----------------
  logic        vld4;
  logic [95:0] res;

  assign vld4 = c4_out[288];

  always_comb begin
    logic signed [ProdW-1:0] t;
    res = '0;
    for (int j = 0; j < 3; j++) begin
      t = $signed(c4_out[ProdW*j +: ProdW]) + $signed(c4_out[144 + ProdW*j +: ProdW])
        + kdo[j];
      if (t > ProdW'(64'sd2147483647)) begin
        res[32*j +: 32] = 32'h7FFF_FFFF;
      end else if (t < ProdW'(-64'sd2147483648)) begin
        res[32*j +: 32] = 32'h8000_0000;
      end else begin
        res[32*j +: 32] = t[31:0];
      end
    end
  end

  // ---------------- two-entry output buffer ----------------
  logic [95:0] buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign adv  = (cnt_q != 2'd2);
  assign push = adv && vld4;
  assign pop  = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res;
  end

  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = buf_q[rd_ptr_q];

endmodule

// ===== rtl/rvr_cordic_cell.sv =====
`timescale 1ns / 1ps
module rvr_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [rvr_pkg::CxW-1:0] x_i,
  input  logic signed [rvr_pkg::CxW-1:0] y_i,
  input  logic signed [rvr_pkg::CzW-1:0] z_i,
  output logic signed [rvr_pkg::CxW-1:0] x_o,
  output logic signed [rvr_pkg::CxW-1:0] y_o,
  output logic signed [rvr_pkg::CzW-1:0] z_o
);
  import rvr_pkg::*;

  localparam logic signed [CzW-1:0] Atan = CzW'(atan_q30(IDX));

  logic signed [CxW-1:0] x_d, y_d, x_q, y_q;
  logic signed [CzW-1:0] z_d, z_q;

  // One rotation step; the sign of the residual angle picks the direction.
  always_comb begin
    if (z_i >= 0) begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/rvr_mul.sv =====
`timescale 1ns / 1ps
module rvr_mul (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [rvr_pkg::MulW-1:0]  a_i,
  input  logic signed [rvr_pkg::MulW-1:0]  b_i,
  output logic signed [rvr_pkg::ProdW-1:0] p_o
);
  import rvr_pkg::*;

  localparam int unsigned HiW  = MagW - HalfW;
  localparam int unsigned SumW = 2 * MagW;

  logic                neg_q, neg2_q;
  logic [MagW-1:0]     ma_q, mb_q;
  logic [HalfW+HiW-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [SumW-1:0]     sum;
  logic [ProdW-1:0]    mag;
  logic signed [ProdW-1:0] p_q;

  // Stage one: sign and magnitude of both operands.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[MulW-1] ^ b_i[MulW-1];
      ma_q  <= a_i[MulW-1] ? MagW'(-a_i) : MagW'(a_i);
      mb_q  <= b_i[MulW-1] ? MagW'(-b_i) : MagW'(b_i);
    end
  end

  // Stage two: four partial products of the split magnitudes.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg_q;
      ll_q <= (HalfW+HiW)'({{HiW{1'b0}}, ma_q[HalfW-1:0]} * {{HiW{1'b0}}, mb_q[HalfW-1:0]});
      lh_q <= (HalfW+HiW)'({{HiW{1'b0}}, ma_q[HalfW-1:0]} * {{HalfW{1'b0}}, mb_q[MagW-1:HalfW]});
      hl_q <= (HalfW+HiW)'({{HalfW{1'b0}}, ma_q[MagW-1:HalfW]} * {{HiW{1'b0}}, mb_q[HalfW-1:0]});
      hh_q <= (HalfW+HiW)'({{HalfW{1'b0}}, ma_q[MagW-1:HalfW]} * {{HalfW{1'b0}}, mb_q[MagW-1:HalfW]});
    end
  end

  // Stage three: sum, drop the Q30 fraction toward zero, restore the sign.
  always_comb begin
    sum = (SumW'(hh_q) << (2 * HalfW)) + (SumW'(lh_q) << HalfW)
        + (SumW'(hl_q) << HalfW) + SumW'(ll_q);
    mag = ProdW'(sum >> QShift);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg2_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/rvr_delay.sv =====
`timescale 1ns / 1ps
module rvr_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] taps_q [D];

  // Shift line that advances with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) taps_q[i] <= '0;
    end else if (en_i) begin
      taps_q[0] <= d_i;
      for (int i = 1; i < D; i++) taps_q[i] <= taps_q[i-1];
    end
  end

  assign d_o = taps_q[D-1];

endmodule
